// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_AT(label, clk, rst_n, !(cond), msg)
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/lpwbe_pkg.sv -----
package lpwbe_pkg;

	typedef enum logic [2:0] {
		REG_ONE_HIGH  = 3'd0,
		REG_ONE_LOW   = 3'd1,
		REG_ZERO_HIGH = 3'd2,
		REG_ZERO_LOW  = 3'd3,
		REG_LATCH     = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_HIGH  = 4'b0010,
		PH_LOW   = 4'b0100,
		PH_LATCH = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic accepted;
		logic buffer_free;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  one_high_ticks;
		logic [7:0]  one_low_ticks;
		logic [7:0]  zero_high_ticks;
		logic [7:0]  zero_low_ticks;
		logic [15:0] latch_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  shift_byte;
		logic [3:0]  bits_left;
		phase_t      phase;
		logic [15:0] tick_count;
		logic        held_valid;
		logic        held_last;
		logic        sending_last;
	} enc_state_t;

	localparam logic [7:0] BYTE_MSB = 8'h80;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// ticks left after the first one; a zero duration acts as one
	function automatic logic [15:0] pulse_rest(input logic [7:0] d);
		logic [7:0] r;
		r = (d == 8'd0) ? 8'd0 : d - 8'd1;
		return {8'd0, r};
	endfunction

endpackage

// ----- rtl/lpwbe_step.sv -----
module lpwbe_step
	import lpwbe_pkg::*;
(
	input  enc_state_t st,
	input  logic [7:0] held_byte,
	input  cfg_t       cfg,
	input  in_item_t   item,
	output enc_state_t nxt,
	output logic [7:0] nxt_held_byte,
	output out_item_t  res
);

	logic take_req;
	logic done;
	logic acc;
	logic [7:0] shifted;

	assign shifted = {st.shift_byte[6:0], 1'b0};

	always_comb begin
		nxt = st;
		nxt_held_byte = held_byte;
		take_req = 1'b0;
		done = 1'b0;
		acc = 1'b0;
		if (item.action) begin
			if (!st.held_valid) begin
				nxt_held_byte = item.data_byte;
				nxt.held_last = item.last_byte;
				nxt.held_valid = 1'b1;
				acc = 1'b1;
			end
		end else begin
			case (st.phase)
				PH_IDLE: begin
					take_req = 1'b1;
				end
				PH_HIGH: begin
					if (st.tick_count != 16'd0) begin
						nxt.tick_count = st.tick_count - 16'd1;
					end else begin
						nxt.phase = PH_LOW;
						nxt.tick_count = pulse_rest((st.shift_byte & BYTE_MSB) != 8'd0 ?
							cfg.one_low_ticks : cfg.zero_low_ticks);
					end
				end
				PH_LOW: begin
					if (st.tick_count != 16'd0) begin
						nxt.tick_count = st.tick_count - 16'd1;
					end else if (st.bits_left > 4'd1) begin
						nxt.bits_left = st.bits_left - 4'd1;
						nxt.shift_byte = shifted;
						nxt.phase = PH_HIGH;
						nxt.tick_count = pulse_rest((shifted & BYTE_MSB) != 8'd0 ?
							cfg.one_high_ticks : cfg.zero_high_ticks);
					end else begin
						nxt.bits_left = 4'd0;
						if (st.sending_last) begin
							nxt.sending_last = 1'b0;
							if (cfg.latch_ticks == 16'd0) begin
								done = 1'b1;
								take_req = 1'b1;
							end else begin
								nxt.phase = PH_LATCH;
								nxt.tick_count = cfg.latch_ticks - 16'd1;
							end
						end else begin
							take_req = 1'b1;
						end
					end
				end
				PH_LATCH: begin
					if (st.tick_count != 16'd0) begin
						nxt.tick_count = st.tick_count - 16'd1;
					end else begin
						done = 1'b1;
						take_req = 1'b1;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
			if (take_req) begin
				if (st.held_valid) begin
					nxt.shift_byte = held_byte;
					nxt.sending_last = st.held_last;
					nxt.held_valid = 1'b0;
					nxt.bits_left = BITS_PER_BYTE;
					nxt.phase = PH_HIGH;
					nxt.tick_count = pulse_rest((held_byte & BYTE_MSB) != 8'd0 ?
						cfg.one_high_ticks : cfg.zero_high_ticks);
				end else begin
					nxt.phase = PH_IDLE;
					nxt.tick_count = 16'd0;
				end
			end
		end
	end

	always_comb begin
		res.line_level = (nxt.phase == PH_HIGH);
		res.accepted = acc;
		res.buffer_free = !nxt.held_valid;
		res.busy_res = (nxt.phase != PH_IDLE);
		res.frame_done = done;
	end

endmodule

// ----- rtl/led_pulse_width_bit_encoder.sv -----
// One-wire LED pulse encoder. Each input beat is either a tick (action 0) or a
// pushed colour byte (action 1); every beat yields exactly one result beat with
// the line level, push acceptance, holding-buffer state, busy and frame_done.
// A beat is registered on entry, the encoder state is updated by one short pass
// of logic, and the result lands in an output register, so one beat a cycle is
// sustained while out_stall does not hold the output. Pulse and latch durations
// come from the config port (index 0..4) and must be written only while idle.
`include "assert_macros.svh"

module led_pulse_width_bit_encoder
	import lpwbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	cfg_t       cfg_q;
	enc_state_t st_q;
	enc_state_t st_nxt;
	logic [7:0] held_byte_q;
	logic [7:0] held_byte_nxt;
	logic       s1_valid_q;
	in_item_t   item_s1;
	out_item_t  res_nxt;
	logic       out_free;
	logic       adv;

	assign out_free = !out_valid || !out_stall;
	assign adv = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{one_high_ticks: 8'd12, one_low_ticks: 8'd8,
				zero_high_ticks: 8'd6, zero_low_ticks: 8'd14, latch_ticks: 16'd1600};
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_ONE_HIGH:  cfg_q.one_high_ticks <= cfg_data[7:0];
				REG_ONE_LOW:   cfg_q.one_low_ticks <= cfg_data[7:0];
				REG_ZERO_HIGH: cfg_q.zero_high_ticks <= cfg_data[7:0];
				REG_ZERO_LOW:  cfg_q.zero_low_ticks <= cfg_data[7:0];
				REG_LATCH:     cfg_q.latch_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	lpwbe_step u_step (
		.st            (st_q),
		.held_byte     (held_byte_q),
		.cfg           (cfg_q),
		.item          (item_s1),
		.nxt           (st_nxt),
		.nxt_held_byte (held_byte_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{shift_byte: 8'd0, bits_left: 4'd0, phase: PH_IDLE,
				tick_count: 16'd0, held_valid: 1'b0, held_last: 1'b0, sending_last: 1'b0};
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
			end
			if (out_free) begin
				out_valid <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			held_byte_q <= held_byte_nxt;
			out_data <= res_nxt;
		end
	end

	`ASSERT_AT(a_stall_needs_s1, clk, arst_n, in_stall |-> s1_valid_q, "stall with empty stage")
	`ASSERT_AT(a_adv_fills_out, clk, arst_n, adv |=> out_valid, "result beat lost")
	`ASSERT_NEVER(a_idle_clean, clk, arst_n,
		(st_q.phase == PH_IDLE) && ((st_q.bits_left != 4'd0) || st_q.sending_last),
		"idle with byte in flight")
	`ASSERT_NEVER(a_high_bits, clk, arst_n,
		(st_q.phase == PH_HIGH) && ((st_q.bits_left == 4'd0) || (st_q.bits_left > BITS_PER_BYTE)),
		"high pulse without bit count")

endmodule
